// ===== design/xylev_pkg.sv =====
// Shared beat types and fixed constants for the XY lattice vortex and energy sum unit.
package xylev_pkg;

	localparam int FIELD_W   = 16;
	localparam int CNT_W     = 17;
	localparam int ENERGY_W  = 32;
	localparam int DELTA_W   = 17;
	localparam int COS_ENT_W = 15;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic [FIELD_W-1:0] theta_site;
		logic [FIELD_W-1:0] theta_next_j;
		logic [FIELD_W-1:0] theta_prev_i_next_j;
		logic [FIELD_W-1:0] theta_prev_i;
		logic [FIELD_W-1:0] theta_prev_k;
		logic [FIELD_W-1:0] theta_prev_i_prev_k;
		logic [FIELD_W-1:0] theta_next_j_prev_k;
		logic [FIELD_W-1:0] theta_next_i;
		logic [FIELD_W-1:0] theta_next_k;
		logic               last_site;
	} in_beat_t;

	typedef struct packed {
		logic [CNT_W-1:0]           vortex_total;
		logic [CNT_W-1:0]           antivortex_total;
		logic signed [ENERGY_W-1:0] energy_total;
	} out_beat_t;

	// Per-site contribution handed from the site evaluator to the accumulators.
	typedef struct packed {
		logic [1:0]                vortex_inc;
		logic [1:0]                antivortex_inc;
		logic signed [DELTA_W-1:0] energy_delta;
		logic                      last_site;
	} site_res_t;

endpackage

// ===== design/xy_lattice_energy_vortex_sum_unit.sv =====
// Top level of the XY lattice vortex counter and bond energy accumulator.
//
// Each input beat carries one lattice site and the neighbor angles it needs. The unit takes
// one beat per clock cycle unless it stalls: the beat is registered, its three plaquettes are
// tested for a winding of exactly plus or minus one turn and its three forward bonds are
// looked up in a quarter-wave cosine table in Q14, and the per-site result is registered
// before it reaches the pass accumulators. A beat with last_site set produces one output
// beat holding the totals of the pass, that site included, and the accumulators clear for
// the next pass; other beats produce nothing. The last site's beat passes through the input
// register and the per-site result register before its totals load the output register.
// The output register holds a finished beat while later sites keep flowing, so the input
// only stalls when a second last site reaches the accumulators while the previous output
// beat is still waiting to be taken. Counts saturate at 131071 and the energy saturates at
// the 32-bit signed limits. Angles are turn fractions of ANGLE_BITS bits; input bits above
// that width are ignored. The cosine table is a constant computed at elaboration, so there
// is no start-up pass after reset.
module xy_lattice_energy_vortex_sum_unit import xylev_pkg::*; #(
	parameter int ANGLE_BITS     = 16,
	parameter int COS_INDEX_BITS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	// Input register stage.
	logic     valid_s1;
	in_beat_t data_s1;

	// Registered per-site contribution.
	logic      valid_s2;
	site_res_t res_s2;
	site_res_t site_res;

	// Pass accumulators and the output register.
	logic [CNT_W-1:0]           vortex_q;
	logic [CNT_W-1:0]           antivortex_q;
	logic signed [ENERGY_W-1:0] energy_q;
	logic                       out_valid_q;
	out_beat_t                  out_data_q;

	logic out_free, s2_fire, s2_free;
	logic [CNT_W:0]             vortex_sum, antivortex_sum;
	logic signed [ENERGY_W:0]   energy_wide;
	logic [CNT_W-1:0]           vortex_new, antivortex_new;
	logic signed [ENERGY_W-1:0] energy_new;

	xylev_site_eval #(
		.ANGLE_BITS     (ANGLE_BITS),
		.COS_INDEX_BITS (COS_INDEX_BITS)
	) u_site_eval (
		.site (data_s1),
		.res  (site_res)
	);

	// A site that does not close a pass never needs the output register, so only a
	// last site can be held back by a full output register.
	assign out_free = !out_valid_q || out_ready;
	assign s2_fire  = valid_s2 && (!res_s2.last_site || out_free);
	assign s2_free  = !valid_s2 || s2_fire;
	assign in_ready = !valid_s1 || s2_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Saturating updates of the pass totals with this site's contribution.
	always_comb begin
		vortex_sum     = {1'b0, vortex_q} + (CNT_W+1)'(res_s2.vortex_inc);
		antivortex_sum = {1'b0, antivortex_q} + (CNT_W+1)'(res_s2.antivortex_inc);
		vortex_new     = vortex_sum[CNT_W] ? CNT_MAX : vortex_sum[CNT_W-1:0];
		antivortex_new = antivortex_sum[CNT_W] ? CNT_MAX : antivortex_sum[CNT_W-1:0];

		energy_wide = {energy_q[ENERGY_W-1], energy_q} + (ENERGY_W+1)'(res_s2.energy_delta);
		if (energy_wide[ENERGY_W] != energy_wide[ENERGY_W-1]) begin
			energy_new = energy_wide[ENERGY_W] ? {1'b1, {(ENERGY_W-1){1'b0}}}
				: {1'b0, {(ENERGY_W-1){1'b1}}};
		end else begin
			energy_new = energy_wide[ENERGY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s2_free) begin
			res_s2 <= site_res;
		end
	end

	// The accumulators clear after the closing site of a pass has been folded in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vortex_q     <= '0;
			antivortex_q <= '0;
			energy_q     <= '0;
		end else if (s2_fire) begin
			if (res_s2.last_site) begin
				vortex_q     <= '0;
				antivortex_q <= '0;
				energy_q     <= '0;
			end else begin
				vortex_q     <= vortex_new;
				antivortex_q <= antivortex_new;
				energy_q     <= energy_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_fire && res_s2.last_site) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire && res_s2.last_site) begin
			out_data_q.vortex_total     <= vortex_new;
			out_data_q.antivortex_total <= antivortex_new;
			out_data_q.energy_total     <= energy_new;
		end
	end

endmodule

// ===== design/xylev_site_eval.sv =====
// Per-site plaquette winding test and bond energy lookup, purely combinational.
module xylev_site_eval import xylev_pkg::*; #(
	parameter int ANGLE_BITS     = 16,
	parameter int COS_INDEX_BITS = 10
) (
	input  in_beat_t  site,
	output site_res_t res
);

	localparam int AW      = ANGLE_BITS;
	localparam int CIB     = COS_INDEX_BITS;
	localparam int QUARTER = 1 << (CIB - 2);
	localparam int QW      = CIB - 1;
	localparam int TBL_W   = (QUARTER + 1) * COS_ENT_W;

	localparam logic [AW-1:0]          HALF   = {1'b1, {(AW-1){1'b0}}};
	localparam logic signed [AW+2:0]   TURN_P = {3'b001, {AW{1'b0}}};
	localparam logic signed [AW+2:0]   TURN_N = -TURN_P;

	localparam longint Q30_ONE = longint'(1) << 30;
	localparam longint PI_Q30  = 64'sd3373259426;
	localparam longint TWO_QTR = 2 * longint'(QUARTER);

	// Quarter-wave cosine in Q14, built at elaboration from a Q30 Taylor series.
	// Term k of the series is divided by (2k-1)(2k), so the twelve steps are written out.
	function automatic logic [TBL_W-1:0] build_qcos();
		logic [TBL_W-1:0] tbl;
		longint           x;
		longint           x2;
		longint           term;
		longint           sum;
		longint           ent;
		tbl = '0;
		for (int m = 0; m <= QUARTER; m++) begin
			x    = (longint'(m) * PI_Q30) / TWO_QTR;
			x2   = (x * x) / Q30_ONE;
			term = Q30_ONE;
			sum  = Q30_ONE;
			term = (-((term * x2) / Q30_ONE)) / 2;
			sum  = sum + term;
			term = (-((term * x2) / Q30_ONE)) / 12;
			sum  = sum + term;
			term = (-((term * x2) / Q30_ONE)) / 30;
			sum  = sum + term;
			term = (-((term * x2) / Q30_ONE)) / 56;
			sum  = sum + term;
			term = (-((term * x2) / Q30_ONE)) / 90;
			sum  = sum + term;
			term = (-((term * x2) / Q30_ONE)) / 132;
			sum  = sum + term;
			term = (-((term * x2) / Q30_ONE)) / 182;
			sum  = sum + term;
			term = (-((term * x2) / Q30_ONE)) / 240;
			sum  = sum + term;
			term = (-((term * x2) / Q30_ONE)) / 306;
			sum  = sum + term;
			term = (-((term * x2) / Q30_ONE)) / 380;
			sum  = sum + term;
			term = (-((term * x2) / Q30_ONE)) / 462;
			sum  = sum + term;
			term = (-((term * x2) / Q30_ONE)) / 552;
			sum  = sum + term;
			ent = (sum < 0) ? 64'd0 : (sum + 32768) / 65536;
			tbl[m*COS_ENT_W +: COS_ENT_W] = ent[COS_ENT_W-1:0];
		end
		return tbl;
	endfunction

	localparam logic [TBL_W-1:0] QCOS = build_qcos();

	function automatic logic [AW-1:0] angle(input logic [FIELD_W-1:0] f);
		logic [AW+FIELD_W-1:0] w;
		w = {{AW{1'b0}}, f};
		return w[AW-1:0];
	endfunction

	function automatic logic signed [AW:0] wrap(input logic [AW-1:0] a,
		input logic [AW-1:0] b);
		logic [AW-1:0] d;
		d = a - b;
		return (d > HALF) ? {1'b1, d} : {1'b0, d};
	endfunction

	// Full-wave cosine from the quarter table; the top two index bits pick the quadrant.
	function automatic logic signed [15:0] bond_cos(input logic [AW-1:0] a,
		input logic [AW-1:0] b);
		logic [AW-1:0]     d;
		logic [AW+CIB-1:0] ext;
		logic [CIB-1:0]    idx;
		logic [1:0]        quad;
		logic [QW-1:0]     r;
		logic [QW-1:0]     addr;
		logic [15:0]       mag;
		d    = a - b;
		ext  = {d, {CIB{1'b0}}};
		idx  = ext[AW+CIB-1 -: CIB];
		quad = idx[CIB-1 -: 2];
		r    = {1'b0, idx[CIB-3:0]};
		addr = quad[0] ? (QW'(QUARTER) - r) : r;
		mag  = {1'b0, QCOS[addr*COS_ENT_W +: COS_ENT_W]};
		return (quad[1] ^ quad[0]) ? -$signed(mag) : $signed(mag);
	endfunction

	logic [AW-1:0] t, tx, txy, ty, tz, tzy, txz, tni, tnk;
	logic signed [AW+2:0] p1, p2, p3;
	logic v1, v2, v3, a1, a2, a3;
	logic signed [DELTA_W-1:0] cos_sum;

	always_comb begin
		t   = angle(site.theta_site);
		tx  = angle(site.theta_next_j);
		txy = angle(site.theta_prev_i_next_j);
		ty  = angle(site.theta_prev_i);
		tz  = angle(site.theta_prev_k);
		tzy = angle(site.theta_prev_i_prev_k);
		txz = angle(site.theta_next_j_prev_k);
		tni = angle(site.theta_next_i);
		tnk = angle(site.theta_next_k);

		p1 = (AW+3)'(wrap(t, tx)) + (AW+3)'(wrap(tx, txy))
			+ (AW+3)'(wrap(txy, ty)) + (AW+3)'(wrap(ty, t));
		p2 = (AW+3)'(wrap(tz, t)) + (AW+3)'(wrap(tzy, tz))
			+ (AW+3)'(wrap(ty, tzy)) + (AW+3)'(wrap(t, ty));
		p3 = (AW+3)'(wrap(tx, t)) + (AW+3)'(wrap(txz, tx))
			+ (AW+3)'(wrap(tz, txz)) + (AW+3)'(wrap(t, tz));

		v1 = (p1 == TURN_P);
		v2 = (p2 == TURN_P);
		v3 = (p3 == TURN_P);
		a1 = (p1 == TURN_N);
		a2 = (p2 == TURN_N);
		a3 = (p3 == TURN_N);

		cos_sum = DELTA_W'(bond_cos(t, tx)) + DELTA_W'(bond_cos(t, tni))
			+ DELTA_W'(bond_cos(t, tnk));

		res.vortex_inc     = {1'b0, v1} + {1'b0, v2} + {1'b0, v3};
		res.antivortex_inc = {1'b0, a1} + {1'b0, a2} + {1'b0, a3};
		res.energy_delta   = -cos_sum;
		res.last_site      = site.last_site;
	end

endmodule

// ===== tb/xylev_winding_energy_checker.sv =====
// Checker that predicts the sweep totals of the XY lattice vortex and energy sum unit.
module xylev_winding_energy_checker import xylev_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_beat_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_beat_t out_data,
	output int        mismatch_count,
	output int        totals_pending,
	output int        sites_seen,
	output int        totals_checked
);

	localparam int     COS_BITS   = 10;
	localparam int     COS_SIZE   = 1 << COS_BITS;
	localparam int     COS_QTR    = COS_SIZE / 4;
	localparam int     TURN       = 1 << FIELD_W;
	localparam int     HALF_TURN  = TURN / 2;
	localparam longint Q30_ONE    = 64'sd1 <<< 30;
	localparam longint PI_Q30     = 64'sd3373259426;
	localparam longint ENERGY_HI  = (64'sd1 <<< (ENERGY_W - 1)) - 1;
	localparam longint ENERGY_LO  = -(64'sd1 <<< (ENERGY_W - 1));

	typedef enum logic [1:0] {WIND_NONE, WIND_VORTEX, WIND_ANTI} winding_e;

	int                         cos_q14 [COS_SIZE];
	logic [CNT_W-1:0]           vortex_acc;
	logic [CNT_W-1:0]           antivortex_acc;
	logic signed [ENERGY_W-1:0] energy_acc;
	out_beat_t                  sweep_totals_q [$];
	out_beat_t                  want;

	// Quarter-wave cosine in Q14 from a Taylor series in Q30, index m of COS_QTR steps.
	function automatic int quarter_cos_q14(input int m);
		longint x, x2, term, acc;
		int k;
		x = (longint'(m) * PI_Q30) / (2 * COS_QTR);
		x2 = (x * x) / Q30_ONE;
		term = Q30_ONE;
		acc = Q30_ONE;
		for (k = 1; k <= 12; k++) begin
			term = -((term * x2) / Q30_ONE) / longint'((2 * k - 1) * (2 * k));
			acc += term;
		end
		if (acc < 0)
			return 0;
		return int'((acc + 32768) / 65536);
	endfunction

	initial begin
		int n;
		for (n = 0; n < COS_SIZE; n++) begin
			case (n / COS_QTR)
				0: cos_q14[n] = quarter_cos_q14(n % COS_QTR);
				1: cos_q14[n] = -quarter_cos_q14(COS_QTR - n % COS_QTR);
				2: cos_q14[n] = -quarter_cos_q14(n % COS_QTR);
				default: cos_q14[n] = quarter_cos_q14(COS_QTR - n % COS_QTR);
			endcase
		end
	end

	// Difference a - b taken modulo one turn and wrapped to (-half, +half].
	function automatic int wrapped_delta(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
		logic [FIELD_W-1:0] d;
		d = a - b;
		return (int'(d) > HALF_TURN) ? int'(d) - TURN : int'(d);
	endfunction

	function automatic winding_e winding_of(input int loop_sum);
		if (loop_sum == TURN)
			return WIND_VORTEX;
		if (loop_sum == -TURN)
			return WIND_ANTI;
		return WIND_NONE;
	endfunction

	function automatic int bond_cos_q14(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
		logic [FIELD_W-1:0] d;
		d = a - b;
		return cos_q14[d >> (FIELD_W - COS_BITS)];
	endfunction

	task automatic report_fault(input string msg);
		$display("[%0t] checker: %s", $time, msg);
		mismatch_count++;
	endtask

	// Folds one site into the running sweep totals and queues them on the last site.
	task automatic accumulate_site(input in_beat_t s);
		int     loop_sum [3];
		longint e;
		loop_sum[0] = wrapped_delta(s.theta_site, s.theta_next_j)
			+ wrapped_delta(s.theta_next_j, s.theta_prev_i_next_j)
			+ wrapped_delta(s.theta_prev_i_next_j, s.theta_prev_i)
			+ wrapped_delta(s.theta_prev_i, s.theta_site);
		loop_sum[1] = wrapped_delta(s.theta_prev_k, s.theta_site)
			+ wrapped_delta(s.theta_prev_i_prev_k, s.theta_prev_k)
			+ wrapped_delta(s.theta_prev_i, s.theta_prev_i_prev_k)
			+ wrapped_delta(s.theta_site, s.theta_prev_i);
		loop_sum[2] = wrapped_delta(s.theta_next_j, s.theta_site)
			+ wrapped_delta(s.theta_next_j_prev_k, s.theta_next_j)
			+ wrapped_delta(s.theta_prev_k, s.theta_next_j_prev_k)
			+ wrapped_delta(s.theta_site, s.theta_prev_k);
		foreach (loop_sum[i]) begin
			case (winding_of(loop_sum[i]))
				WIND_VORTEX: if (vortex_acc != CNT_MAX) vortex_acc++;
				WIND_ANTI:   if (antivortex_acc != CNT_MAX) antivortex_acc++;
				default: ;
			endcase
		end
		e = longint'(energy_acc) - bond_cos_q14(s.theta_site, s.theta_next_j)
			- bond_cos_q14(s.theta_site, s.theta_next_i)
			- bond_cos_q14(s.theta_site, s.theta_next_k);
		if (e > ENERGY_HI)
			e = ENERGY_HI;
		if (e < ENERGY_LO)
			e = ENERGY_LO;
		energy_acc = e[ENERGY_W-1:0];
		if (s.last_site) begin
			sweep_totals_q.push_back('{vortex_acc, antivortex_acc, energy_acc});
			vortex_acc = '0;
			antivortex_acc = '0;
			energy_acc = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vortex_acc = '0;
			antivortex_acc = '0;
			energy_acc = '0;
			sweep_totals_q.delete();
			totals_pending = 0;
			sites_seen = 0;
			totals_checked = 0;
		end else begin
			// A totals beat taken at this edge belongs to a sweep closed earlier.
			if (out_valid && out_ready) begin
				if (sweep_totals_q.size() == 0) begin
					report_fault("totals beat arrived with no sweep outstanding");
				end else begin
					want = sweep_totals_q.pop_front();
					if (out_data.vortex_total !== want.vortex_total)
						report_fault($sformatf("vortex_total got %0d want %0d",
							out_data.vortex_total, want.vortex_total));
					if (out_data.antivortex_total !== want.antivortex_total)
						report_fault($sformatf("antivortex_total got %0d want %0d",
							out_data.antivortex_total, want.antivortex_total));
					if (out_data.energy_total !== want.energy_total)
						report_fault($sformatf("energy_total got %0d want %0d",
							out_data.energy_total, want.energy_total));
					totals_checked++;
				end
			end
			if (in_valid && in_ready) begin
				accumulate_site(in_data);
				sites_seen++;
			end
			totals_pending = sweep_totals_q.size();
		end
	end

endmodule

// ===== tb/xy_lattice_energy_vortex_sum_unit_tb.sv =====
// Testbench top that streams lattice sites into the vortex and energy sum unit and gives the verdict.
module xy_lattice_energy_vortex_sum_unit_tb;
	import xylev_pkg::*;

	// A stretch this long with no beat moving on either channel means the unit hung.
	localparam int QUIET_LIMIT  = 4000;
	// The totals beat trails its last site through the unit's registers; leave some margin after the drain.
	localparam int DRAIN_CYCLES = 8;

	// Angles that sit on the wrap boundaries and the thirds of a turn.
	localparam logic [FIELD_W-1:0] A_ZERO   = 16'h0000;
	localparam logic [FIELD_W-1:0] A_QTR    = 16'h4000;
	localparam logic [FIELD_W-1:0] A_HALF   = 16'h8000;
	localparam logic [FIELD_W-1:0] A_3QTR   = 16'hC000;
	localparam logic [FIELD_W-1:0] A_THIRD  = 16'd21845;
	localparam logic [FIELD_W-1:0] A_2THIRD = 16'd43690;
	localparam logic [FIELD_W-1:0] A_ONES   = 16'hFFFF;

	// Length of the sweeps that repeat one site, so the totals build up over many beats.
	// The vortex site yields three vortices and +3.0 of energy per site, the antivortex
	// site two antivortices and -3.0 of energy per site.
	localparam int REPEAT_SITES = 20;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_data;

	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles = 0;
	int mismatch_count;
	int totals_pending;
	int sites_seen;
	int totals_checked;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	xy_lattice_energy_vortex_sum_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	xylev_winding_energy_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.mismatch_count (mismatch_count),
		.totals_pending (totals_pending),
		.sites_seen     (sites_seen),
		.totals_checked (totals_checked)
	);

	// The receiver decides afresh at every falling edge whether it takes a totals beat.
	always @(negedge clk) begin
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: any accepted beat on either side restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_beat_t make_site(
		input logic [FIELD_W-1:0] t, input logic [FIELD_W-1:0] tx,
		input logic [FIELD_W-1:0] txy, input logic [FIELD_W-1:0] ty,
		input logic [FIELD_W-1:0] tz, input logic [FIELD_W-1:0] tzy,
		input logic [FIELD_W-1:0] txz, input logic [FIELD_W-1:0] tni,
		input logic [FIELD_W-1:0] tnk, input logic is_last);
		in_beat_t s;
		s.theta_site          = t;
		s.theta_next_j        = tx;
		s.theta_prev_i_next_j = txy;
		s.theta_prev_i        = ty;
		s.theta_prev_k        = tz;
		s.theta_prev_i_prev_k = tzy;
		s.theta_next_j_prev_k = txz;
		s.theta_next_i        = tni;
		s.theta_next_k        = tnk;
		s.last_site           = is_last;
		return s;
	endfunction

	// Half of the angles are uniform. The rest land on or just beside a quarter-turn
	// multiple, so the exact half turn and the values on either side of it come up often.
	function automatic logic [FIELD_W-1:0] random_angle();
		int v;
		if ($urandom_range(1) == 0) begin
			v = $urandom;
		end else begin
			v = int'($urandom_range(3)) * 16384 + int'($urandom_range(4)) - 2;
		end
		return v[FIELD_W-1:0];
	endfunction

	function automatic in_beat_t random_site(input logic is_last);
		return make_site(random_angle(), random_angle(), random_angle(), random_angle(),
			random_angle(), random_angle(), random_angle(), random_angle(), random_angle(),
			is_last);
	endfunction

	// Presents one site beat and returns at the falling edge after it was taken. Valid is
	// only lowered for a sender gap, so back-to-back beats keep it high.
	task automatic drive_site(input in_beat_t site);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= site;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Random sweeps of mostly 2 to 16 sites with some single-site sweeps mixed in, which
	// keeps totals beats frequent enough to load the output stall path.
	task automatic run_random_sweeps(input int site_budget);
		int left, len, i;
		left = site_budget;
		while (left > 0) begin
			len = ($urandom_range(7) == 0) ? 1 : $urandom_range(16, 2);
			if (len > left)
				len = left;
			for (i = 1; i <= len; i++)
				drive_site(random_site(i == len));
			left -= len;
		end
	endtask

	task automatic run_repeated_sweep(input in_beat_t site, input int count);
		int i;
		site.last_site = 1'b0;
		for (i = 1; i < count; i++)
			drive_site(site);
		site.last_site = 1'b1;
		drive_site(site);
	endtask

	initial begin
		in_beat_t vortex_site, anti_site;
		int i;

		in_valid = 1'b0;
		in_data  = '0;
		arst_n = 1'b0;
		send_idle_pct = 28;
		recv_idle_pct = 88;

		// With t = 0, tx = tz = txz = half and ty = 0, all three plaquettes wind +1 only
		// because an exact half turn wraps to the positive side; all three bonds are
		// anti-aligned, so each site adds the largest energy.
		vortex_site = make_site(A_ZERO, A_HALF, A_QTR, A_ZERO, A_HALF, A_3QTR, A_HALF,
			A_HALF, A_HALF, 1'b0);
		// Thirds of a turn going the other way make two plaquettes wind -1, and the bonds
		// are aligned, so each site subtracts the largest energy.
		anti_site = make_site(A_ZERO, A_ZERO, A_THIRD, A_2THIRD, A_THIRD, A_ZERO, A_2THIRD,
			A_ZERO, A_ZERO, 1'b0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed sites. All-zero and all-one angles give aligned bonds and no winding.
		drive_site(make_site(A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO,
			A_ZERO, 1'b1));
		drive_site(make_site(A_ONES, A_ONES, A_ONES, A_ONES, A_ONES, A_ONES, A_ONES, A_ONES,
			A_ONES, 1'b1));
		vortex_site.last_site = 1'b1;
		drive_site(vortex_site);
		anti_site.last_site = 1'b1;
		drive_site(anti_site);
		// Four half-turn steps around the first plaquette make a winding of two turns,
		// which must count as neither vortex nor antivortex.
		drive_site(make_site(A_ZERO, A_HALF, A_ZERO, A_HALF, A_ZERO, A_ZERO, A_ZERO, A_QTR,
			A_3QTR, 1'b1));
		// Alternating bit patterns in one three-site sweep, closed by a lone half-turn bond.
		drive_site(make_site(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
			16'hAAAA, 16'h5555, 16'hAAAA, 1'b0));
		drive_site(make_site(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
			16'h5555, 16'hAAAA, 16'h5555, 1'b0));
		drive_site(make_site(A_ZERO, A_HALF, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO,
			A_ZERO, 1'b1));
		// One step either side of the half turn wraps to opposite signs.
		drive_site(make_site(16'h8001, A_ZERO, 16'h7FFF, A_ZERO, 16'h8001, 16'h7FFF, A_ZERO,
			16'h7FFF, 16'h8001, 1'b1));
		// Back-to-back sweep ends against a slow receiver force the input to stall.
		for (i = 0; i < 6; i++)
			drive_site(random_site(1'b1));

		// Random sweeps: sender gaps and a mostly stalled receiver, then the reverse, then
		// both sides at full rate.
		run_random_sweeps(330);
		send_idle_pct = 88;
		recv_idle_pct = 28;
		run_random_sweeps(330);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_sweeps(330);

		// Two sweeps of one repeated site: the vortex count and the energy climb, then the
		// antivortex count climbs and the energy falls.
		run_repeated_sweep(vortex_site, REPEAT_SITES);
		run_repeated_sweep(anti_site, REPEAT_SITES);
		in_valid <= 1'b0;

		while (totals_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Streamed %0d site beats and checked %0d sweep totals under idle mixes",
			sites_seen, totals_checked);
		$display("covering half-turn wraps, double windings and repeated-site sweeps.");
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
design/xylev_pkg.sv
design/xylev_site_eval.sv
design/xy_lattice_energy_vortex_sum_unit.sv
tb/xylev_winding_energy_checker.sv
tb/xy_lattice_energy_vortex_sum_unit_tb.sv
